// File: hw/rtl/tsos_pkg.sv
// Shared types and constants for the transpose self-organising search table.
// No dependencies; imported by the cell, the chain and the top level.
package tsos_pkg;

  // Fixed field widths of the item and result ports.
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 6;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  // Widest stored word that the block supports.
  localparam int WIDE_W  = 64;

  // Item operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Search token that walks along the row of cells.
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POS_W-1:0] pos;
  } tok_t;

endpackage

// File: hw/rtl/tsos_cell.sv
// One table cell: holds a single word, compares it with the search key when
// the token is here, and swaps with its left neighbour on a hit. Uses tsos_pkg.
module tsos_cell #(
  parameter int K         = 0,
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [WORD_BITS-1:0]        key,
  input  logic                        in_range,
  input  logic                        wr_en,
  input  logic [tsos_pkg::SLOT_W-1:0] wr_slot,
  input  logic [WORD_BITS-1:0]        wr_data,
  input  logic [WORD_BITS-1:0]        left_word,
  input  logic [WORD_BITS-1:0]        right_word,
  input  logic                        right_hit,
  input  tsos_pkg::tok_t              tok_in,
  output logic [WORD_BITS-1:0]        word_out,
  output logic                        hit,
  output tsos_pkg::tok_t              tok_out
);
  import tsos_pkg::*;

  localparam int CW = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  // Position reported when this cell matches: one to the left, or zero.
  localparam logic [POS_W-1:0] HIT_POS = (K > 0) ? POS_W'(K - 1) : '0;

  logic [WORD_BITS-1:0] word;
  tok_t                 tok;
  logic                 slot_sel;

  assign slot_sel = wr_en && (CW'(wr_slot) == CW'(K));
  assign word_out = word;

  // A hit is the first match of the walk, inside the searched range.
  assign hit = tok.valid && !tok.found && in_range && (word == key);

  // Pass the token on, marking it found here if this cell matched.
  assign tok_out = '{valid: tok.valid,
                     found: tok.found | hit,
                     pos:   hit ? HIT_POS : tok.pos};

  // Stored word: direct write, or one half of a transposition.
  always_ff @(posedge clk) begin
    if (slot_sel) begin
      word <= wr_data;
    end else if (hit && (K > 0)) begin
      word <= left_word;
    end else if (right_hit) begin
      word <= right_word;
    end
  end

  // Token register; only its valid flag needs clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

endmodule

// File: hw/rtl/tsos_chain.sv
// Row of DEPTH table cells linked to their neighbours, with the token entering
// at slot zero and leaving after the last slot. Uses tsos_pkg and tsos_cell.
module tsos_chain #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [WORD_BITS-1:0]        key,
  input  logic                        in_range,
  input  logic                        wr_en,
  input  logic [tsos_pkg::SLOT_W-1:0] wr_slot,
  input  logic [WORD_BITS-1:0]        wr_data,
  input  tsos_pkg::tok_t              tok_first,
  output tsos_pkg::tok_t              tok_last
);
  import tsos_pkg::*;

  logic [WORD_BITS-1:0] words   [DEPTH];
  logic [WORD_BITS-1:0] left_w  [DEPTH];
  logic [WORD_BITS-1:0] right_w [DEPTH];
  logic                 hits    [DEPTH];
  logic                 right_h [DEPTH];
  tok_t                 tok_i   [DEPTH];
  tok_t                 tok_o   [DEPTH];

  assign tok_last = tok_o[DEPTH-1];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    // Neighbour links; the ends of the row are tied off.
    if (k == 0) begin : g_first
      assign left_w[k] = words[k];
      assign tok_i[k]  = tok_first;
    end else begin : g_inner
      assign left_w[k] = words[k-1];
      assign tok_i[k]  = tok_o[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w[k] = '0;
      assign right_h[k] = 1'b0;
    end else begin : g_mid
      assign right_w[k] = words[k+1];
      assign right_h[k] = hits[k+1];
    end

    tsos_cell #(
      .K         (k),
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .in_range   (in_range),
      .wr_en      (wr_en),
      .wr_slot    (wr_slot),
      .wr_data    (wr_data),
      .left_word  (left_w[k]),
      .right_word (right_w[k]),
      .right_hit  (right_h[k]),
      .tok_in     (tok_i[k]),
      .word_out   (words[k]),
      .hit        (hits[k]),
      .tok_out    (tok_o[k])
    );
  end

endmodule

// File: hw/rtl/transpose_self_organizing_search.sv
// Transpose self-organising search table. A write item stores its value into
// one slot and returns found = 0. A search item sends a token along a row of
// DEPTH cells, one cell per cycle, comparing the key with each slot below
// entry_count; the first hit at slot i swaps slots i and i-1 and reports
// position i-1 (0 for a hit at slot 0). The result of a search is registered
// once the token has left the last cell of the row, and no new item is taken
// while the walk is under way. If the output register is free, a write result
// is presented in the next cycle and another item may follow at once. A result
// that is ready while the previous one is still waiting holds the input off
// until the waiting one is taken. The table is not cleared by reset; only
// slots that have been written may be searched.
// Depends on tsos_pkg and tsos_chain.
module transpose_self_organizing_search #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tsos_pkg::COUNT_W-1:0] entry_count,
  // Item channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [tsos_pkg::SLOT_W-1:0]  slot,
  input  logic signed [tsos_pkg::VALUE_W-1:0] value,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [tsos_pkg::POS_W-1:0]   position
);
  import tsos_pkg::*;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]           state;
  logic [COUNT_W-1:0]   slots_used;
  logic [IDX_W-1:0]     idx;
  logic [WORD_BITS-1:0] key;
  logic                 pend_found;
  logic [POS_W-1:0]     pend_pos;

  logic [WIDE_W-1:0]    value_ext;
  logic [WORD_BITS-1:0] word_in;
  logic                 accept_in;
  logic                 is_write;
  logic                 is_search;
  logic                 in_range;
  logic                 out_free;
  logic                 walk_done;
  tok_t                 tok_first;
  tok_t                 tok_last;

  // Only the low WORD_BITS of the zero-extended value are stored and compared.
  assign value_ext = {{(WIDE_W - VALUE_W){1'b0}}, value};
  assign word_in   = value_ext[WORD_BITS-1:0];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign is_write  = accept_in && (opcode == OP_WRITE);
  assign is_search = accept_in && (opcode == OP_SEARCH);
  assign out_free  = !out_valid || out_ready;
  assign walk_done = (state == S_WALK) && tok_last.valid;

  // The token sits in cell idx; it may hit only below the slot count.
  assign in_range  = CMP_W'(idx) < CMP_W'(slots_used);
  assign tok_first = '{valid: is_search, found: 1'b0, pos: '0};

  tsos_chain #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .in_range  (in_range),
    .wr_en     (is_write),
    .wr_slot   (slot),
    .wr_data   (word_in),
    .tok_first (tok_first),
    .tok_last  (tok_last)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
    end else if (cfg_valid && cfg_ready) begin
      slots_used <= entry_count;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (is_search) begin
            key   <= word_in;
            idx   <= '0;
            state <= S_WALK;
          end else if (is_write) begin
            if (out_free) begin
              out_valid <= 1'b1;
              found     <= 1'b0;
              position  <= '0;
            end else begin
              pend_found <= 1'b0;
              pend_pos   <= '0;
              state      <= S_HOLD;
            end
          end
        end
        S_WALK: begin
          idx <= idx + 1'b1;
          if (walk_done) begin
            if (out_free) begin
              out_valid <= 1'b1;
              found     <= tok_last.found;
              position  <= tok_last.pos;
              state     <= S_IDLE;
            end else begin
              pend_found <= tok_last.found;
              pend_pos   <= tok_last.pos;
              state      <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            found     <= pend_found;
            position  <= pend_pos;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The token leaves the row only while a search walk is under way.
  a_tok_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok_last.valid |-> (state == S_WALK))
    else $error("search token left the cell row outside a walk");

  // An accepted search always starts a walk.
  a_search_walks: assert property (@(posedge clk) disable iff (rst)
    is_search |=> (state == S_WALK))
    else $error("accepted search did not start a walk");

  // A walk continues until the token reaches the end of the row.
  a_walk_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) && !tok_last.valid |=> (state == S_WALK))
    else $error("walk ended before the token left the row");

  // A write with a free output register reports a miss in the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    is_write && out_free |=> out_valid && !found && (position == '0))
    else $error("write transfer did not give an empty result");
`endif

endmodule
